### rtl/text_console_scroll_buffer_defines.svh
// Assertion macros shared by the scroll buffer RTL.
`ifndef TEXT_CONSOLE_SCROLL_BUFFER_DEFINES_SVH
`define TEXT_CONSOLE_SCROLL_BUFFER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCSB_CHECK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCSB_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tcsb_pkg.sv
// Package for the text console scroll buffer: sizes, codes and result type.
package tcsb_pkg;

    localparam int ROWS_DEF = 32;
    localparam int COLS_DEF = 128;

    localparam int CHAR_W     = 8;
    localparam int LINE_W     = 5;
    localparam int COLUMN_W   = 7;
    localparam int OUT_ROW_W  = 5;
    localparam int OUT_COL_W  = 8;
    localparam int CFG_ROWS_W = 6;
    localparam int CFG_COLS_W = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ROWS_W-1:0] CFG_ROWS_RST = 6'd32;
    localparam logic [CFG_COLS_W-1:0] CFG_COLS_RST = 8'd128;

    typedef enum logic [0:0] {
        REG_ROWS_IN_USE = 1'b0,
        REG_COLS_IN_USE = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        KIND_WRITE = 1'b0,
        KIND_READ  = 1'b1
    } kind_t;

    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7E;

    typedef struct packed {
        logic                 hit;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] top;
    } res_t;

    function automatic logic is_accepted(input logic [CHAR_W-1:0] ch);
        is_accepted = (ch == CH_LF) || (ch == CH_BS) || (ch == CH_TAB) ||
                      ((ch >= CH_PRINT_LO) && (ch <= CH_PRINT_HI));
    endfunction

endpackage

### rtl/text_console_scroll_buffer.sv
// Text console scroll buffer: ring of text rows with cursor, line lengths and cell reads.
//
// Input channel (in_valid/in_stall): one request per cycle unless stalled. kind 0 writes
// char_code at the cursor (newline, backspace, tab, printable 0x20..0x7E; other codes
// ignored), kind 1 reads the cell at screen_line/column counted from the top row.
// Output channel (out_valid/out_stall): exactly one result per request, in order,
// carrying read_char and the cursor row, cursor column and top row after the request.
// A request is registered in the memory stage (s1_reg) and then in the output register
// (out_reg) before out_valid rises; while in_stall is low, one request is taken per cycle,
// set by the combinational cursor update and one cell memory access per request.
// Cells live in a 2^clog2(ROWS) x 2^clog2(COLS) byte memory with a registered read
// port; line lengths sit in flops and are cleared at reset, so no clearing pass is needed.
// Reset: cursor at row 0 column 0, top row 1, rows_in_use 32, cols_in_use 128.
// The user must write the cfg port (cfg_we/cfg_index/cfg_data) only while the block is
// idle; the block itself does not enforce it. After a rows_in_use write, in_stall stays
// high while cursor and top row are folded into the new ring size.
// When out_stall holds, one result waits in the output register and one more request
// is taken into the memory stage; in_stall rises when both are full or while folding.
`include "text_console_scroll_buffer_defines.svh"

module text_console_scroll_buffer
    import tcsb_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic [CHAR_W-1:0]     char_code,
    input  logic [LINE_W-1:0]     screen_line,
    input  logic [COLUMN_W-1:0]   column,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CHAR_W-1:0]     read_char,
    output logic [OUT_ROW_W-1:0]  cursor_row,
    output logic [OUT_COL_W-1:0]  cursor_col,
    output logic [OUT_ROW_W-1:0]  top_row
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int RCW   = RW + 1;
    localparam int PW    = ((RW > LINE_W) ? RW : LINE_W) + 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = 2 ** AW;

    logic [CFG_ROWS_W-1:0] cfg_rows_reg;
    logic [CFG_COLS_W-1:0] cfg_cols_reg;

    logic [RW-1:0]        write_row_reg, write_row_next;
    logic [OUT_COL_W-1:0] write_col_reg, write_col_next;
    logic [RW-1:0]        first_row_reg, first_row_next;
    logic [OUT_COL_W-1:0] len_reg [ROWS];

    logic [CHAR_W-1:0] cell_mem [DEPTH];
    logic [CHAR_W-1:0] mem_q_reg;

    logic              s1_valid_reg;
    res_t              s1_reg, s1_next;
    logic              out_valid_reg;
    res_t              out_reg;
    logic [CHAR_W-1:0] read_char_reg;

    logic [RCW-1:0]       rows_eff, rows_last;
    logic [OUT_COL_W-1:0] cols_eff;
    logic                 wr_big, fr_big, norm_busy;
    logic                 in_accept, s1_adv, wr_item;

    logic                 acc, close;
    logic [RW-1:0]        row_inc, new_row, first_inc;
    logic [OUT_COL_W-1:0] col_a;
    logic                 cell_we;
    logic [CHAR_W-1:0]    cell_wdata;
    logic [AW-1:0]        cell_waddr, cell_raddr;

    logic [PW-1:0]        phys_sum, phys_fold;
    logic [RW-1:0]        phys;
    logic                 line_ok, hit;

    // effective ring and line sizes
    always_comb
    begin
        if (cfg_rows_reg == '0)
            rows_eff = RCW'(1);
        else if (32'(cfg_rows_reg) > 32'(ROWS))
            rows_eff = RCW'(ROWS);
        else
            rows_eff = RCW'(cfg_rows_reg);
        rows_last = rows_eff - RCW'(1);

        if (cfg_cols_reg == '0)
            cols_eff = OUT_COL_W'(1);
        else if (32'(cfg_cols_reg) > 32'(COLS))
            cols_eff = OUT_COL_W'(COLS);
        else
            cols_eff = cfg_cols_reg;
    end

    assign wr_big    = {1'b0, write_row_reg} >= rows_eff;
    assign fr_big    = {1'b0, first_row_reg} >= rows_eff;
    assign norm_busy = wr_big || fr_big;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = norm_busy || (s1_valid_reg && !s1_adv);
    assign in_accept = in_valid && !in_stall;
    assign wr_item   = in_accept && (kind == KIND_WRITE);

    // cursor update for write requests, and cursor/top row folding after a ring size change
    always_comb
    begin
        acc       = is_accepted(char_code);
        close     = acc && ((char_code == CH_LF) || (write_col_reg >= cols_eff));
        row_inc   = ({1'b0, write_row_reg} == rows_last) ? '0 : write_row_reg + RW'(1);
        new_row   = close ? row_inc : write_row_reg;
        first_inc = ({1'b0, first_row_reg} == rows_last) ? '0 : first_row_reg + RW'(1);
        col_a     = close ? '0 : write_col_reg;

        cell_we    = 1'b0;
        cell_wdata = (char_code == CH_TAB) ? CH_SPACE : char_code;
        cell_waddr = {new_row, CW'(col_a)};

        write_row_next = write_row_reg;
        write_col_next = write_col_reg;
        first_row_next = first_row_reg;

        if (norm_busy)
        begin
            if (wr_big)
                write_row_next = RW'({1'b0, write_row_reg} - rows_eff);
            if (fr_big)
                first_row_next = RW'({1'b0, first_row_reg} - rows_eff);
        end
        else if (wr_item && acc)
        begin
            write_row_next = new_row;
            if (close && (new_row == first_row_reg))
                first_row_next = first_inc;
            if (char_code == CH_BS)
                write_col_next = (col_a != '0) ? col_a - OUT_COL_W'(1) : '0;
            else if (char_code == CH_LF)
                write_col_next = col_a;
            else
            begin
                cell_we        = 1'b1;
                write_col_next = col_a + OUT_COL_W'(1);
            end
        end
    end

    // read mapping through the top row
    always_comb
    begin
        line_ok    = PW'(screen_line) < PW'(rows_eff);
        phys_sum   = PW'(first_row_reg) + PW'(screen_line);
        phys_fold  = (phys_sum >= PW'(rows_eff)) ? phys_sum - PW'(rows_eff) : phys_sum;
        phys       = RW'(phys_fold);
        hit        = (kind == KIND_READ) && line_ok &&
                     ({1'b0, column} < len_reg[phys]);
        cell_raddr = {phys, CW'(column)};

        s1_next.hit = hit;
        s1_next.row = OUT_ROW_W'(write_row_next);
        s1_next.col = write_col_next;
        s1_next.top = OUT_ROW_W'(first_row_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_rows_reg <= CFG_ROWS_RST;
            cfg_cols_reg <= CFG_COLS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROWS_IN_USE: cfg_rows_reg <= cfg_data[CFG_ROWS_W-1:0];
                REG_COLS_IN_USE: cfg_cols_reg <= cfg_data[CFG_COLS_W-1:0];
                default:         cfg_cols_reg <= cfg_cols_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_row_reg <= '0;
            write_col_reg <= '0;
            first_row_reg <= RW'(1);
        end
        else
        begin
            write_row_reg <= write_row_next;
            write_col_reg <= write_col_next;
            first_row_reg <= first_row_next;
        end
    end

    // line lengths; a closed line keeps its final length unless the ring wraps onto it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
                len_reg[i] <= '0;
        end
        else if (wr_item)
        begin
            if (close && (write_row_next != write_row_reg))
                len_reg[write_row_reg] <= write_col_reg;
            len_reg[write_row_next] <= write_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
            cell_mem[cell_waddr] <= cell_wdata;
        if (in_accept && (kind == KIND_READ))
            mem_q_reg <= cell_mem[cell_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_reg <= s1_next;
        if (s1_adv)
        begin
            out_reg       <= s1_reg;
            read_char_reg <= s1_reg.hit ? mem_q_reg : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_char  = read_char_reg;
    assign cursor_row = out_reg.row;
    assign cursor_col = out_reg.col;
    assign top_row    = out_reg.top;

    `TCSB_CHECK_IMPLY(a_ring_folded, in_accept, !wr_big && !fr_big, "cursor row outside ring at request")
    `TCSB_CHECK_NEXT(a_s1_drains, s1_adv, out_valid_reg, "memory stage result lost on advance")
    `TCSB_CHECK_IMPLY(a_no_overrun, in_accept, !s1_valid_reg || s1_adv, "request taken over a held result")

endmodule

### bench/text_console_scroll_buffer_test.sv
// Self-checking testbench for the text console scroll buffer: directed and random requests.
module text_console_scroll_buffer_test;
    import tcsb_pkg::*;

    typedef struct packed {
        kind_t                 kind;
        logic [CHAR_W-1:0]     ch;
        logic [LINE_W-1:0]     line;
        logic [COLUMN_W-1:0]   col;
    } console_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0]     ch;
        logic [OUT_ROW_W-1:0]  row;
        logic [OUT_COL_W-1:0]  col;
        logic [OUT_ROW_W-1:0]  top;
    } console_view_t;

    localparam int PHASES = 9;
    localparam int PHASE_ROWS [PHASES] = '{0, 32, 4, 4, 63, 33, 7, 2, 1};
    localparam int PHASE_COLS [PHASES] = '{1, 128, 5, 2, 0, 200, 12, 3, 128};
    localparam int PHASE_REQS [PHASES] = '{40, 80, 100, 60, 60, 60, 120, 70, 60};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [0:0]            cfg_index = REG_ROWS_IN_USE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  kind = KIND_WRITE;
    logic [CHAR_W-1:0]     char_code = '0;
    logic [LINE_W-1:0]     screen_line = '0;
    logic [COLUMN_W-1:0]   column = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [CHAR_W-1:0]     read_char;
    logic [OUT_ROW_W-1:0]  cursor_row;
    logic [OUT_COL_W-1:0]  cursor_col;
    logic [OUT_ROW_W-1:0]  top_row;

    // console shadow state
    logic [CHAR_W-1:0] cells [ROWS_DEF][COLS_DEF];
    int unsigned row_len [ROWS_DEF] = '{default: 0};
    int unsigned wr_row = 0;
    int unsigned wr_col = 0;
    int unsigned first_shown = 1;
    int unsigned rows_reg = 32'(CFG_ROWS_RST);
    int unsigned cols_reg = 32'(CFG_COLS_RST);

    console_req_t  pending_requests [$];
    console_view_t expected_views [$];
    console_req_t  on_wire;
    int            burst_left = 1;
    int            gap_left = 0;
    int            stall_mode = 0;
    int            mode_left = 0;
    int unsigned   stall_tick = 0;
    int            mismatches = 0;

    text_console_scroll_buffer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .char_code   (char_code),
        .screen_line (screen_line),
        .column      (column),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_char   (read_char),
        .cursor_row  (cursor_row),
        .cursor_col  (cursor_col),
        .top_row     (top_row)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_count(input int unsigned value, input int unsigned limit);
        if (value == 0)
            return 1;
        return (value > limit) ? limit : value;
    endfunction

    function automatic console_view_t console_step(input console_req_t req);
        console_view_t view;
        int unsigned   rows;
        int unsigned   cols;
        int unsigned   phys;
        logic          takes;
        rows = clamp_count(rows_reg, ROWS_DEF);
        cols = clamp_count(cols_reg, COLS_DEF);
        view.ch = '0;
        wr_row = wr_row % rows;
        first_shown = first_shown % rows;
        if (req.kind == KIND_WRITE)
        begin
            takes = (req.ch == CH_LF) || (req.ch == CH_BS) || (req.ch == CH_TAB) ||
                    ((req.ch >= CH_PRINT_LO) && (req.ch <= CH_PRINT_HI));
            if (takes)
            begin
                if (req.ch == CH_LF || wr_col >= cols)
                begin
                    row_len[wr_row] = wr_col;
                    wr_col = 0;
                    wr_row = (wr_row + 1) % rows;
                    if (wr_row == first_shown)
                        first_shown = (first_shown + 1) % rows;
                end
                if (req.ch == CH_BS)
                begin
                    if (wr_col != 0)
                        wr_col--;
                end
                else if (req.ch != CH_LF)
                begin
                    cells[wr_row][wr_col] = (req.ch == CH_TAB) ? CH_SPACE : req.ch;
                    wr_col++;
                end
            end
            row_len[wr_row] = wr_col;
        end
        else if (req.line < rows)
        begin
            phys = (first_shown + req.line) % rows;
            if (req.col < row_len[phys])
                view.ch = cells[phys][req.col];
        end
        view.row = wr_row[OUT_ROW_W-1:0];
        view.col = wr_col[OUT_COL_W-1:0];
        view.top = first_shown[OUT_ROW_W-1:0];
        return view;
    endfunction

    function automatic console_req_t random_request(input int unsigned rows, input int unsigned cols);
        console_req_t req;
        int unsigned  pick;
        req.kind = KIND_WRITE;
        req.ch   = CHAR_W'($urandom_range(0, 255));
        req.line = LINE_W'($urandom_range(0, 31));
        req.col  = COLUMN_W'($urandom_range(0, 127));
        pick = $urandom_range(0, 99);
        if (pick < 45)
            req.ch = CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
        else if (pick < 55)
            req.ch = CH_LF;
        else if (pick < 63)
            req.ch = CH_BS;
        else if (pick < 68)
            req.ch = CH_TAB;
        else if (pick >= 75)
        begin
            req.kind = KIND_READ;
            if ($urandom_range(0, 4) != 0)
            begin
                req.line = LINE_W'($urandom_range(0, rows - 1));
                req.col  = COLUMN_W'($urandom_range(0, (cols < 127) ? cols : 127));
            end
        end
        return req;
    endfunction

    task automatic queue_write(input logic [CHAR_W-1:0] ch);
        console_req_t req;
        req.kind = KIND_WRITE;
        req.ch   = ch;
        req.line = LINE_W'($urandom_range(0, 31));
        req.col  = COLUMN_W'($urandom_range(0, 127));
        pending_requests.push_back(req);
    endtask

    task automatic queue_read(input logic [LINE_W-1:0] line, input logic [COLUMN_W-1:0] col);
        console_req_t req;
        req.kind = KIND_READ;
        req.ch   = CHAR_W'($urandom_range(0, 255));
        req.line = line;
        req.col  = col;
        pending_requests.push_back(req);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_views.size() != 0);
    endtask

    task automatic set_geometry(input int unsigned rows, input int unsigned cols);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROWS_IN_USE;
        cfg_data  <= rows[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= REG_COLS_IN_USE;
        cfg_data  <= cols[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        rows_reg = rows & 32'h3F;
        cols_reg = cols & 32'hFF;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // request driver: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_views.push_back(console_step(on_wire));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    on_wire = pending_requests.pop_front();
                    kind        <= on_wire.kind;
                    char_code   <= on_wire.ch;
                    screen_line <= on_wire.line;
                    column      <= on_wire.col;
                    in_valid    <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        console_view_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_views.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got char %0d row %0d col %0d top %0d",
                             $time, read_char, cursor_row, cursor_col, top_row);
                    mismatches++;
                end
                else
                begin
                    want = expected_views.pop_front();
                    compare_field("read_char", want.ch, read_char);
                    compare_field("cursor_row", 8'(want.row), 8'(cursor_row));
                    compare_field("cursor_col", want.col, cursor_col);
                    compare_field("top_row", 8'(want.top), 8'(top_row));
                end
            end
            stall_tick++;
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= 1'($urandom_range(0, 1));
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= (stall_tick % 3 == 0);
            endcase
        end
    end

    initial
    begin
        int unsigned rows;
        int unsigned cols;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: 32 rows, first_shown 1, so row 0 appears as line 31
        queue_write(8'h41);
        queue_write(8'h7E);
        queue_write(CH_SPACE);
        queue_write(CH_TAB);
        queue_write(8'h00);
        queue_write(8'h1F);
        queue_write(8'h7F);
        queue_write(8'hFF);
        queue_write(CH_BS);
        queue_read(31, 0);
        queue_read(31, 1);
        queue_read(31, 2);
        queue_read(31, 3);
        queue_read(31, 127);
        queue_read(0, 0);
        queue_write(CH_LF);
        queue_write(CH_BS);
        queue_write(8'h5A);
        queue_read(0, 0);
        queue_write(CH_LF);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            set_geometry(PHASE_ROWS[p], PHASE_COLS[p]);
            rows = clamp_count(PHASE_ROWS[p], ROWS_DEF);
            cols = clamp_count(PHASE_COLS[p], COLS_DEF);
            for (int n = 0; n < PHASE_REQS[p]; n++)
                pending_requests.push_back(random_request(rows, cols));
            // park the cursor at column 0 before the ring size changes
            if (p + 1 < PHASES && PHASE_ROWS[p + 1] != PHASE_ROWS[p])
                queue_write(CH_LF);
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_views.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/tcsb_pkg.sv
rtl/text_console_scroll_buffer.sv
bench/text_console_scroll_buffer_test.sv
